@@ src/buffer_frame_pin_table_macros.svh @@
// assertion macros shared by the assertions of the checker file
`ifndef BUFFER_FRAME_PIN_TABLE_MACROS_SVH
`define BUFFER_FRAME_PIN_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BFPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bfpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bfpt_pkg
// Shared constants, codes and beat types of the buffer frame pin table.
// ----------------------------------------------------------------------------
package bfpt_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int TAG_BITS   = 16;
  localparam int PIN_BITS   = 8;
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0]    CFG_RESET = 5'd16;
  localparam logic [PIN_BITS-1:0] PIN_MAX   = {PIN_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_PIN   = 2'd0,
    MODE_UNPIN = 2'd1,
    MODE_NEW   = 2'd2,
    MODE_FREE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_DONE           = 3'd0,
    ST_EVICT_UNPINNED = 3'd1,
    ST_EVICT_PINNED   = 3'd2,
    ST_NOT_RESIDENT   = 3'd3,
    ST_UNDERFLOW      = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_e;

  // input beat
  typedef struct packed {
    mode_e       mode;
    logic [15:0] page_tag;
  } cmd_t;

  // result beat
  typedef struct packed {
    status_e     status;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_tag;
    logic [4:0]  unpinned_count;
  } result_t;

  // search record passed from cell to cell
  typedef struct packed {
    logic                valid;
    mode_e               mode;
    logic [TAG_BITS-1:0] tag;
    logic                m_found;
    logic [IDX_W-1:0]    m_idx;
    logic [PIN_BITS-1:0] m_pins;
    logic                e_found;
    logic [IDX_W-1:0]    e_idx;
    logic                u_found;
    logic [IDX_W-1:0]    u_idx;
    logic [TAG_BITS-1:0] u_tag;
    logic                min_seen;
    logic [IDX_W-1:0]    min_idx;
    logic [PIN_BITS-1:0] min_pins;
    logic [TAG_BITS-1:0] min_tag;
    logic [CNT_W-1:0]    cnt;
  } scan_t;

  // frame update broadcast to all cells
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic                valid;
    logic [TAG_BITS-1:0] tag;
    logic [PIN_BITS-1:0] pins;
  } frame_wr_t;

endpackage

@@ src/buffer_frame_pin_table.sv @@
// Each request's search record is registered in every frame cell in turn,
//   and the result beat is registered after the last cell.
// One request at a time: busy holds off a new start while the search record
//   walks the chain of frame cells one per cycle.
// Busy is low again in the strobe cycle, so the next start may land there.
// Reset: all frames empty with zero pins, frames_in_use back to 16; the result
//   lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
// buffer_frame_pin_table
// Frame table of a page buffer pool: pin, unpin, new page and free requests
// against a row of frame cells that a search record sweeps in order.
// ----------------------------------------------------------------------------
module buffer_frame_pin_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bfpt_pkg::cmd_t             cmd_i,
  output logic                       result_valid_o,
  output bfpt_pkg::result_t          result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bfpt_pkg::CFG_W-1:0] cfg_data_i
);

  bfpt_pkg::fsm_e                state_q, state_d;
  logic [bfpt_pkg::CFG_W-1:0]    frames_in_use_q;
  logic [31:0]                   cfg_wide;
  logic [bfpt_pkg::CNT_W-1:0]    active_n;
  bfpt_pkg::scan_t               scan_w [bfpt_pkg::NUM_FRAMES+1];
  bfpt_pkg::frame_wr_t           wr;
  bfpt_pkg::result_t             res;
  bfpt_pkg::result_t             result_q;
  logic                          result_valid_q;
  logic                          accept;

  assign accept = start && !busy;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= bfpt_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frames_in_use_q <= cfg_data_i;
    end
  end

  // clamp the frame count to one .. NUM_FRAMES
  assign cfg_wide = 32'(frames_in_use_q);
  assign active_n = (cfg_wide == 32'd0) ? bfpt_pkg::CNT_W'(1)
                  : (cfg_wide > 32'(bfpt_pkg::NUM_FRAMES))
                    ? bfpt_pkg::CNT_W'(bfpt_pkg::NUM_FRAMES)
                    : bfpt_pkg::CNT_W'(cfg_wide);

  // fresh search record enters the first cell
  always_comb begin
    scan_w[0]       = '0;
    scan_w[0].valid = accept;
    scan_w[0].mode  = cmd_i.mode;
    scan_w[0].tag   = bfpt_pkg::TAG_BITS'(32'(cmd_i.page_tag));
  end

  // row of frame cells
  for (genvar g = 0; g < bfpt_pkg::NUM_FRAMES; g++) begin : g_cell
    bfpt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (bfpt_pkg::IDX_W'(g)),
      .active_n_i (active_n),
      .scan_i     (scan_w[g]),
      .wr_i       (wr),
      .scan_o     (scan_w[g+1])
    );
  end

  bfpt_resolve u_resolve (
    .scan_i   (scan_w[bfpt_pkg::NUM_FRAMES]),
    .wr_o     (wr),
    .result_o (res)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpt_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfpt_pkg::FSM_IDLE: begin
        if (start) begin
          state_d = bfpt_pkg::FSM_SCAN;
        end
      end
      bfpt_pkg::FSM_SCAN: begin
        if (scan_w[bfpt_pkg::NUM_FRAMES].valid) begin
          state_d = bfpt_pkg::FSM_IDLE;
        end
      end
      default: state_d = bfpt_pkg::FSM_IDLE;
    endcase
  end

  // handshake outputs, a register write never shares an edge with a request
  always_comb begin
    busy        = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      bfpt_pkg::FSM_IDLE: cfg_ready_o = !start;
      bfpt_pkg::FSM_SCAN: busy = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= scan_w[bfpt_pkg::NUM_FRAMES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_w[bfpt_pkg::NUM_FRAMES].valid) begin
      result_q <= res;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

@@ src/bfpt_cell.sv @@
// ----------------------------------------------------------------------------
// bfpt_cell
// One frame of the table: holds valid, tag and pin count, folds its frame into
// the passing search record and registers the record for the next cell.
// ----------------------------------------------------------------------------
module bfpt_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bfpt_pkg::IDX_W-1:0]     cell_idx_i,
  input  logic [bfpt_pkg::CNT_W-1:0]     active_n_i,
  input  bfpt_pkg::scan_t                scan_i,
  input  bfpt_pkg::frame_wr_t            wr_i,
  output bfpt_pkg::scan_t                scan_o
);

  logic                          valid_q;
  logic [bfpt_pkg::TAG_BITS-1:0] tag_q;
  logic [bfpt_pkg::PIN_BITS-1:0] pins_q;
  bfpt_pkg::scan_t               scan_d, scan_q;
  logic                          active;
  logic                          zero_pins;

  assign active    = bfpt_pkg::CNT_W'(cell_idx_i) < active_n_i;
  assign zero_pins = (pins_q == '0);

  // frame storage, written by the broadcast update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tag_q   <= '0;
      pins_q  <= '0;
    end else if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      valid_q <= wr_i.valid;
      tag_q   <= wr_i.tag;
      pins_q  <= wr_i.pins;
    end
  end

  // fold this frame into the record
  always_comb begin
    scan_d = scan_i;
    if (scan_i.valid && active) begin
      if (!scan_i.m_found && valid_q && (tag_q == scan_i.tag)) begin
        scan_d.m_found = 1'b1;
        scan_d.m_idx   = cell_idx_i;
        scan_d.m_pins  = pins_q;
      end
      if (!scan_i.e_found && !valid_q) begin
        scan_d.e_found = 1'b1;
        scan_d.e_idx   = cell_idx_i;
      end
      if (!scan_i.u_found && zero_pins) begin
        scan_d.u_found = 1'b1;
        scan_d.u_idx   = cell_idx_i;
        scan_d.u_tag   = tag_q;
      end
      if (!scan_i.min_seen || (pins_q < scan_i.min_pins)) begin
        scan_d.min_seen = 1'b1;
        scan_d.min_idx  = cell_idx_i;
        scan_d.min_pins = pins_q;
        scan_d.min_tag  = tag_q;
      end
      if (zero_pins) begin
        scan_d.cnt = scan_i.cnt + bfpt_pkg::CNT_W'(1);
      end
    end
  end

  // hand the record to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

@@ src/bfpt_resolve.sv @@
// ----------------------------------------------------------------------------
// bfpt_resolve
// Turns the finished search record into the frame update and the result beat.
// ----------------------------------------------------------------------------
module bfpt_resolve (
  input  bfpt_pkg::scan_t      scan_i,
  output bfpt_pkg::frame_wr_t  wr_o,
  output bfpt_pkg::result_t    result_o
);

  logic                          old_zero;
  logic                          new_zero;
  logic [bfpt_pkg::IDX_W-1:0]    idx;
  logic [bfpt_pkg::TAG_BITS-1:0] ev_tag;
  logic [bfpt_pkg::CNT_W-1:0]    cnt;

  // decide the target frame, its new contents and the status
  always_comb begin
    wr_o            = '0;
    result_o        = '0;
    result_o.status = bfpt_pkg::ST_DONE;
    old_zero        = 1'b0;
    new_zero        = 1'b0;
    idx             = '0;
    ev_tag          = '0;
    wr_o.tag        = scan_i.tag;
    wr_o.valid      = 1'b1;
    case (scan_i.mode)
      bfpt_pkg::MODE_NEW: begin
        if (scan_i.e_found) begin
          idx = scan_i.e_idx;
        end else if (scan_i.u_found) begin
          idx                    = scan_i.u_idx;
          ev_tag                 = scan_i.u_tag;
          result_o.status        = bfpt_pkg::ST_EVICT_UNPINNED;
          result_o.evicted_valid = 1'b1;
          old_zero               = 1'b1;
        end else begin
          idx                    = scan_i.min_idx;
          ev_tag                 = scan_i.min_tag;
          result_o.status        = bfpt_pkg::ST_EVICT_PINNED;
          result_o.evicted_valid = 1'b1;
        end
        // empty frames always carry zero pins
        if (scan_i.e_found) begin
          old_zero = 1'b1;
        end
        wr_o.en   = 1'b1;
        wr_o.pins = bfpt_pkg::PIN_BITS'(1);
      end
      default: begin
        if (!scan_i.m_found) begin
          result_o.status = bfpt_pkg::ST_NOT_RESIDENT;
        end else begin
          idx      = scan_i.m_idx;
          old_zero = (scan_i.m_pins == '0);
          case (scan_i.mode)
            bfpt_pkg::MODE_PIN: begin
              wr_o.en   = 1'b1;
              wr_o.pins = (scan_i.m_pins == bfpt_pkg::PIN_MAX) ? scan_i.m_pins
                          : scan_i.m_pins + bfpt_pkg::PIN_BITS'(1);
            end
            bfpt_pkg::MODE_UNPIN: begin
              if (old_zero) begin
                result_o.status = bfpt_pkg::ST_UNDERFLOW;
                new_zero        = 1'b1;
              end else begin
                wr_o.en   = 1'b1;
                wr_o.pins = scan_i.m_pins - bfpt_pkg::PIN_BITS'(1);
                new_zero  = (scan_i.m_pins == bfpt_pkg::PIN_BITS'(1));
              end
            end
            default: begin
              // free clears the frame, pinned or not
              wr_o.en    = 1'b1;
              wr_o.valid = 1'b0;
              wr_o.tag   = '0;
              wr_o.pins  = '0;
              new_zero   = 1'b1;
            end
          endcase
        end
      end
    endcase
    wr_o.idx = idx;
    wr_o.en  = wr_o.en & scan_i.valid;
    cnt      = scan_i.cnt - bfpt_pkg::CNT_W'(old_zero) + bfpt_pkg::CNT_W'(new_zero);
    result_o.frame_index    = 4'(32'(idx));
    result_o.evicted_tag    = 16'(32'(ev_tag));
    result_o.unpinned_count = 5'(32'(cnt));
  end

endmodule

@@ src/bfpt_checker.sv @@
// ----------------------------------------------------------------------------
// bfpt_checker
// Port-level checks of the buffer frame pin table, bound to the top level.
// ----------------------------------------------------------------------------
`include "buffer_frame_pin_table_macros.svh"

module bfpt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input bfpt_pkg::result_t result_o
);

  // an accepted beat keeps the block busy
  `BFPT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept not followed by busy")

  // results never come back to back
  `BFPT_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o, "back to back result")

  // a result only shows once the search is over
  `BFPT_ASSERT_NOW(a_strobe_idle, clk_i, rst_ni, result_valid_o, !busy, "result while busy")

  // a miss reports frame index zero and evicts nothing
  `BFPT_ASSERT_NOW(a_miss_clean, clk_i, rst_ni, result_valid_o && (result_o.status == bfpt_pkg::ST_NOT_RESIDENT), (result_o.frame_index == 4'd0) && !result_o.evicted_valid && (result_o.evicted_tag == 16'd0), "miss reports a frame")

  // eviction flag agrees with the status
  `BFPT_ASSERT_NOW(a_evict_status, clk_i, rst_ni, result_valid_o, result_o.evicted_valid == ((result_o.status == bfpt_pkg::ST_EVICT_UNPINNED) || (result_o.status == bfpt_pkg::ST_EVICT_PINNED)), "eviction flag mismatch")

endmodule

bind buffer_frame_pin_table bfpt_checker u_bfpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

@@ verif/tb_buffer_frame_pin_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buffer frame pin table: a queue of requests and
// register writes feeds a clocked driver, a predictor tracks the frame table,
// and a clocked monitor checks every result beat against the oldest expectation.
// ----------------------------------------------------------------------------
module tb;
  import bfpt_pkg::*;

  typedef enum logic [1:0] {
    JOB_REQ,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    cmd_t             req;
    logic [CFG_W-1:0] frames;
  } job_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  cmd_t             cmd_i       = '0;
  logic             result_valid_o;
  result_t          result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  // work queue, expected results and the predicted frame table
  job_t                pending_jobs[$];
  result_t             expected_results[$];
  logic                tbl_valid[NUM_FRAMES];
  logic [15:0]         tbl_tag[NUM_FRAMES];
  logic [PIN_BITS-1:0] tbl_pins[NUM_FRAMES];
  logic [CFG_W-1:0]    pool_frames = CFG_RESET;
  int                  beats_issued   = 0;
  int                  beats_returned = 0;
  int                  failures       = 0;
  logic [15:0]         hot_tags[12];

  buffer_frame_pin_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // frame table update and expected result for one accepted request
  task automatic apply_request(input cmd_t c);
    result_t r;
    int      n;
    int      hit;
    int      pick;
    int      best;
    int      zeros;
    n = (pool_frames == 0) ? 1 :
        ((pool_frames > NUM_FRAMES) ? NUM_FRAMES : int'(pool_frames));
    r = '0;
    r.status = ST_DONE;
    hit = -1;
    pick = -1;
    zeros = 0;
    if (c.mode == MODE_NEW) begin
      // first empty frame, then lowest unpinned, then fewest pins
      for (int i = 0; i < n; i++)
        if (pick < 0 && !tbl_valid[i]) pick = i;
      if (pick < 0) begin
        for (int i = 0; i < n; i++)
          if (pick < 0 && tbl_pins[i] == 0) pick = i;
        if (pick >= 0) begin
          r.status = ST_EVICT_UNPINNED;
        end else begin
          best = 0;
          for (int i = 1; i < n; i++)
            if (tbl_pins[i] < tbl_pins[best]) best = i;
          pick = best;
          r.status = ST_EVICT_PINNED;
        end
        r.evicted_valid = 1'b1;
        r.evicted_tag = tbl_tag[pick];
      end
      r.frame_index = 4'(pick);
      tbl_valid[pick] = 1'b1;
      tbl_tag[pick] = c.page_tag;
      tbl_pins[pick] = 1;
    end else begin
      // lowest matching valid frame in use
      for (int i = 0; i < n; i++)
        if (hit < 0 && tbl_valid[i] && tbl_tag[i] == c.page_tag) hit = i;
      if (hit < 0) begin
        r.status = ST_NOT_RESIDENT;
      end else begin
        r.frame_index = 4'(hit);
        case (c.mode)
          MODE_PIN: begin
            if (tbl_pins[hit] != PIN_MAX) tbl_pins[hit] = tbl_pins[hit] + 1'b1;
          end
          MODE_UNPIN: begin
            if (tbl_pins[hit] == 0) r.status = ST_UNDERFLOW;
            else tbl_pins[hit] = tbl_pins[hit] - 1'b1;
          end
          default: begin
            tbl_valid[hit] = 1'b0;
            tbl_tag[hit] = '0;
            tbl_pins[hit] = '0;
          end
        endcase
      end
    end
    for (int i = 0; i < n; i++)
      if (tbl_pins[i] == 0) zeros++;
    r.unpinned_count = 5'(zeros);
    expected_results = {expected_results, r};
  endtask

  task automatic add_req(input mode_e m, input logic [15:0] t);
    job_t j;
    j = '0;
    j.kind = JOB_REQ;
    j.req.mode = m;
    j.req.page_tag = t;
    pending_jobs = {pending_jobs, j};
  endtask

  task automatic add_cfg(input logic [CFG_W-1:0] v);
    job_t j;
    j = '0;
    j.kind = JOB_CFG;
    j.frames = v;
    pending_jobs = {pending_jobs, j};
  endtask

  task automatic add_drain();
    job_t j;
    j = '0;
    j.kind = JOB_DRAIN;
    pending_jobs = {pending_jobs, j};
  endtask

  // mostly tags from a small hot set so requests hit resident pages
  task automatic add_random_req();
    int          roll;
    mode_e       m;
    logic [15:0] t;
    roll = $urandom_range(99);
    if (roll < 30) m = MODE_NEW;
    else if (roll < 60) m = MODE_PIN;
    else if (roll < 85) m = MODE_UNPIN;
    else m = MODE_FREE;
    if ($urandom_range(99) < 75) t = hot_tags[$urandom_range(11)];
    else t = 16'($urandom);
    add_req(m, t);
  endtask

  // sender holds back on about 23 of 100 tries, but never while beats 150 to 259 go out
  function automatic bit take_gap();
    if (beats_issued >= 150 && beats_issued < 260) return 1'b0;
    return $urandom_range(99) < 23;
  endfunction

  // driver: one assignment per handshake signal per edge
  always @(posedge clk_i) begin
    logic nxt_start;
    logic nxt_cfg;
    if (rst_ni) begin
      nxt_start = start;
      nxt_cfg = cfg_valid_i;
      if (result_valid_o) beats_returned++;
      if (start && !busy) begin
        apply_request(cmd_i);
        beats_issued++;
        void'(pending_jobs.pop_front());
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pool_frames = cfg_data_i;
        void'(pending_jobs.pop_front());
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && pending_jobs.size() != 0) begin
        case (pending_jobs[0].kind)
          JOB_REQ: begin
            if (!take_gap()) begin
              nxt_start = 1'b1;
              cmd_i <= pending_jobs[0].req;
            end
          end
          JOB_CFG: begin
            if (beats_issued == beats_returned && !take_gap()) begin
              nxt_cfg = 1'b1;
              cfg_data_i <= pending_jobs[0].frames;
            end
          end
          default: begin
            if (beats_issued == beats_returned) void'(pending_jobs.pop_front());
          end
        endcase
      end
      start <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding");
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", int'(want.status), int'(result_o.status));
        check_field("frame_index", want.frame_index, result_o.frame_index);
        check_field("evicted_valid", want.evicted_valid, result_o.evicted_valid);
        check_field("evicted_tag", want.evicted_tag, result_o.evicted_tag);
        check_field("unpinned_count", want.unpinned_count, result_o.unpinned_count);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [CFG_W-1:0] plan[10];
    logic [15:0]      sat_tag;
    plan = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd2, 5'd17, 5'd5, 5'd0, 5'd16, 5'd4};
    for (int i = 0; i < NUM_FRAMES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_tag[i] = '0;
      tbl_pins[i] = '0;
    end
    foreach (hot_tags[i]) hot_tags[i] = 16'($urandom);
    hot_tags[0] = 16'h0000;
    hot_tags[1] = 16'hFFFF;

    // directed: misses, pin and unpin, underflow, duplicates, frees
    add_req(MODE_PIN, 16'h0000);
    add_req(MODE_UNPIN, 16'hFFFF);
    add_req(MODE_FREE, 16'h1234);
    add_req(MODE_NEW, 16'hFFFF);
    add_req(MODE_NEW, 16'h0000);
    add_req(MODE_PIN, 16'hFFFF);
    add_req(MODE_UNPIN, 16'hFFFF);
    add_req(MODE_UNPIN, 16'hFFFF);
    add_req(MODE_UNPIN, 16'hFFFF);
    add_req(MODE_NEW, 16'hFFFF);
    add_req(MODE_FREE, 16'hFFFF);
    add_req(MODE_PIN, 16'hFFFF);
    add_req(MODE_FREE, 16'h0000);
    add_req(MODE_NEW, 16'hA5A5);
    // two frames: fill, evict pinned on a tie, evict unpinned, miss past the pool
    add_cfg(5'd2);
    add_req(MODE_NEW, 16'h5A5A);
    add_req(MODE_NEW, 16'h1111);
    add_req(MODE_UNPIN, 16'h1111);
    add_req(MODE_NEW, 16'h2222);
    add_req(MODE_PIN, 16'hFFFF);
    // zero acts as one frame
    add_cfg(5'd0);
    add_req(MODE_NEW, 16'h3333);
    add_req(MODE_FREE, 16'h5A5A);
    // above the frame count acts as all frames, old contents kept
    add_cfg(5'd31);
    add_req(MODE_PIN, 16'hFFFF);
    add_req(MODE_NEW, 16'h0001);

    // random phases over several pool sizes
    for (int p = 0; p < 10; p++) begin
      add_cfg(plan[p]);
      for (int k = 0; k < 10; k++) begin
        if (p == 4 && k == 5) add_drain();
        add_random_req();
      end
    end

    // pin count saturation on a single frame
    sat_tag = 16'($urandom);
    add_cfg(5'd1);
    add_req(MODE_NEW, sat_tag);
    for (int k = 0; k < 256; k++) add_req(MODE_PIN, sat_tag);
    add_req(MODE_UNPIN, sat_tag);
    add_req(MODE_PIN, sat_tag);
    add_req(MODE_NEW, 16'($urandom));
    add_cfg(5'd16);
    for (int k = 0; k < 20; k++) add_random_req();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_jobs.size() != 0 || beats_issued != beats_returned) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (expected_results.size() != 0)
      $error("%0d expected results never arrived", expected_results.size());
    if (failures == 0 && expected_results.size() == 0) begin
      $display("buffer_frame_pin_table: match");
    end else begin
      $display("buffer_frame_pin_table: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #(64'd2_000_000);
    $display("buffer_frame_pin_table: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/bfpt_pkg.sv
src/bfpt_cell.sv
src/bfpt_resolve.sv
src/buffer_frame_pin_table.sv
src/bfpt_checker.sv
verif/tb_buffer_frame_pin_table.sv
